FILE: rtl/core/ppsm_pkg.sv
// Shared types and constants for the pulse period speed meter.
// No dependencies; imported by pulse_period_speed_meter.
package ppsm_pkg;

   localparam int TICK_W     = 32;  // timestamp and time value width
   localparam int WFRAC      = 8;   // fraction bits of the smoothing weight
   localparam int QUOT_W     = 30;  // frequency and speed width
   localparam int DIV_STEPS  = QUOT_W;
   localparam int DCNT_W     = $clog2(DIV_STEPS);
   localparam int BCNT_W     = $clog2(WFRAC);
   localparam int PROD_W     = TICK_W + WFRAC + 1;  // signed weight * difference
   localparam int RSP_DATA_W = 128;

   localparam logic [QUOT_W-1:0] FREQ_NUM  = 30'd1000000000;  // 1e9 mHz*us
   localparam logic [QUOT_W-1:0] SPEED_NUM = 30'd666666666;   // 2e9/3 mrpm*us

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BLEND,
      ST_WRITE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/core/pulse_period_speed_meter.sv
// Pulse period / high time meter with smoothing, frequency and speed outputs.
// Depends on ppsm_pkg (types and constants).

// Each edge event (req_tuser = level, req_tdata = 32-bit microsecond tick)
// yields one result transfer. A rising edge measures the period since the last
// rising edge, a falling edge the high time since the last rising edge; tick
// differences wrap modulo 2^32. Measurements after the first are smoothed as
// (w*old + (256-w)*sample) >> 8 with w = csr_data (0 = no smoothing). The
// smoothing runs bit-serially over the 8 weight bits, then a write-back step
// stores it; frequency (1e9/period) and speed (666666666/period) then come
// from two restoring dividers that retire one quotient bit per cycle. The
// result sits in an output register, so the next event is taken while the
// previous result waits. The weight is captured when an event is accepted,
// so a weight write takes effect from the next accepted event on.
module pulse_period_speed_meter
   import ppsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // edge events
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TICK_W-1:0]     req_tdata,   // [31:0] tick
   input  logic                  req_tuser,   // [0] level (1 rising, 0 falling)
   // results
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] period_us, [63:32] high_us,
                                              // [93:64] freq_millihz,
                                              // [123:94] speed_millirpm,
                                              // [124] period_valid, rest zero
   // weight register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [WFRAC-1:0]      csr_data
);

   state_type state_ff, state_in;

   // measurement state
   logic [TICK_W-1:0] last_rise_ff, last_rise_in;
   logic              rise_seen_ff, rise_seen_in;
   logic [TICK_W-1:0] period_value_ff, period_value_in;
   logic              period_known_ff, period_known_in;
   logic [TICK_W-1:0] high_value_ff, high_value_in;
   logic              high_known_ff, high_known_in;
   logic [WFRAC-1:0]  weight_ff, weight_in;

   // serial blend
   logic [TICK_W-1:0] sample_ff, sample_in;
   logic [PROD_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [WFRAC-1:0]  wsh_ff, wsh_in;
   logic [BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic              bsel_ff, bsel_in;   // 1: period, 0: high time

   // dividers
   logic [QUOT_W-1:0] numf_ff, numf_in, nums_ff, nums_in;
   logic [TICK_W-1:0] remf_ff, remf_in, rems_ff, rems_in;
   logic [QUOT_W-1:0] qf_ff, qf_in, qs_ff, qs_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   // output register
   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   // control
   logic req_xfer;
   logic start_blend;
   logic div_start;
   logic rsp_load;

   logic              level;
   logic [TICK_W-1:0] tick;
   logic [TICK_W-1:0] diff;
   logic [TICK_W-1:0] blend_old;
   logic [TICK_W+1:0] blend_sum;
   logic [TICK_W:0]   trial_f, trial_s, sub_f, sub_s, divisor;
   logic              ge_f, ge_s;
   logic              per_nz;

   assign level     = req_tuser;
   assign tick      = req_tdata;
   assign req_xfer  = req_tvalid & req_tready;
   assign csr_ready = 1'b1;
   assign diff      = tick - last_rise_ff;  // wraps modulo 2^32

   // smoothing only when the measurement already holds a value
   assign start_blend = req_xfer && rise_seen_ff &&
                        (level ? period_known_ff : high_known_ff);
   assign blend_old   = level ? period_value_ff : high_value_ff;

   // floor((w*old + (256-w)*s)/256) = s + floor(w*(old-s)/256)
   assign blend_sum = {2'b00, sample_ff} + {acc_ff[PROD_W-1], acc_ff[PROD_W-1:WFRAC]};

   assign divisor = {1'b0, period_value_ff};
   assign trial_f = {remf_ff, numf_ff[QUOT_W-1]};
   assign trial_s = {rems_ff, nums_ff[QUOT_W-1]};
   assign ge_f    = trial_f >= divisor;
   assign ge_s    = trial_s >= divisor;
   assign sub_f   = trial_f - divisor;
   assign sub_s   = trial_s - divisor;
   assign per_nz  = period_known_ff && (period_value_ff != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = start_blend ? ST_BLEND : ST_DIVIDE;
            end
         end
         ST_BLEND: begin
            if (bcnt_ff == BCNT_W'(WFRAC - 1)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (dcnt_ff == DCNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_xfer && !start_blend;
         end
         ST_WRITE: begin
            div_start = 1'b1;
         end
         ST_EMIT: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      last_rise_in    = last_rise_ff;
      rise_seen_in    = rise_seen_ff;
      period_value_in = period_value_ff;
      period_known_in = period_known_ff;
      high_value_in   = high_value_ff;
      high_known_in   = high_known_ff;
      weight_in       = weight_ff;
      sample_in       = sample_ff;
      mcand_in        = mcand_ff;
      acc_in          = acc_ff;
      wsh_in          = wsh_ff;
      bcnt_in         = bcnt_ff;
      bsel_in         = bsel_ff;
      numf_in         = numf_ff;
      nums_in         = nums_ff;
      remf_in         = remf_ff;
      rems_in         = rems_ff;
      qf_in           = qf_ff;
      qs_in           = qs_ff;
      dcnt_in         = dcnt_ff;
      rsp_tdata_in    = rsp_tdata_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;

      if (csr_valid && csr_ready) begin
         weight_in = csr_data;
      end

      if (req_xfer) begin
         if (level) begin
            last_rise_in = tick;
            rise_seen_in = 1'b1;
            if (rise_seen_ff && !period_known_ff) begin
               period_value_in = diff;   // first period taken as is
               period_known_in = 1'b1;
            end
         end else if (rise_seen_ff && !high_known_ff) begin
            high_value_in = diff;
            high_known_in = 1'b1;
         end
         if (start_blend) begin
            sample_in = diff;
            mcand_in  = {{(PROD_W-TICK_W){1'b0}}, blend_old} -
                        {{(PROD_W-TICK_W){1'b0}}, diff};
            acc_in    = '0;
            wsh_in    = weight_ff;
            bcnt_in   = '0;
            bsel_in   = level;
         end
      end

      // one weight bit per cycle, LSB first
      if (state_ff == ST_BLEND) begin
         if (wsh_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = {mcand_ff[PROD_W-2:0], 1'b0};
         wsh_in   = {1'b0, wsh_ff[WFRAC-1:1]};
         bcnt_in  = bcnt_ff + 1'b1;
      end

      if (state_ff == ST_WRITE) begin
         if (bsel_ff) begin
            period_value_in = blend_sum[TICK_W-1:0];
         end else begin
            high_value_in = blend_sum[TICK_W-1:0];
         end
      end

      if (div_start) begin
         numf_in = FREQ_NUM;
         nums_in = SPEED_NUM;
         remf_in = '0;
         rems_in = '0;
         qf_in   = '0;
         qs_in   = '0;
         dcnt_in = '0;
      end

      // restoring division, one quotient bit per cycle
      if (state_ff == ST_DIVIDE) begin
         remf_in = ge_f ? sub_f[TICK_W-1:0] : trial_f[TICK_W-1:0];
         rems_in = ge_s ? sub_s[TICK_W-1:0] : trial_s[TICK_W-1:0];
         qf_in   = {qf_ff[QUOT_W-2:0], ge_f};
         qs_in   = {qs_ff[QUOT_W-2:0], ge_s};
         numf_in = {numf_ff[QUOT_W-2:0], 1'b0};
         nums_in = {nums_ff[QUOT_W-2:0], 1'b0};
         dcnt_in = dcnt_ff + 1'b1;
      end

      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {3'b000,
                          period_known_ff,
                          per_nz ? qs_ff : {QUOT_W{1'b0}},
                          per_nz ? qf_ff : {QUOT_W{1'b0}},
                          high_known_ff ? high_value_ff : {TICK_W{1'b0}},
                          period_known_ff ? period_value_ff : {TICK_W{1'b0}}};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rise_seen_ff    <= 1'b0;
         period_known_ff <= 1'b0;
         high_known_ff   <= 1'b0;
         weight_ff       <= '0;
         rsp_tvalid_ff   <= 1'b0;
         last_rise_ff    <= '0;
         period_value_ff <= '0;
         high_value_ff   <= '0;
      end else begin
         state_ff        <= state_in;
         rise_seen_ff    <= rise_seen_in;
         period_known_ff <= period_known_in;
         high_known_ff   <= high_known_in;
         weight_ff       <= weight_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
         last_rise_ff    <= last_rise_in;
         period_value_ff <= period_value_in;
         high_value_ff   <= high_value_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff    <= sample_in;
      mcand_ff     <= mcand_in;
      acc_ff       <= acc_in;
      wsh_ff       <= wsh_in;
      bcnt_ff      <= bcnt_in;
      bsel_ff      <= bsel_in;
      numf_ff      <= numf_in;
      nums_ff      <= nums_in;
      remf_ff      <= remf_in;
      rems_ff      <= rems_in;
      qf_ff        <= qf_in;
      qs_ff        <= qs_in;
      dcnt_ff      <= dcnt_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // an accepted event keeps the input closed until its result is built
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken again right after a transfer");

   // a period is only ever known after a rising edge was seen
   a_period_needs_rise: assert property (@(posedge clock) disable iff (reset)
      period_known_ff |-> rise_seen_ff)
      else $error("period known without a rising edge");

   // smoothing only runs on a value that already holds a measurement
   a_blend_on_known: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BLEND) |-> (bsel_ff ? period_known_ff : high_known_ff))
      else $error("smoothing an unknown value");

   // no period, no frequency or speed
   a_zero_rates: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tdata_ff[124]) |->
         (rsp_tdata_ff[123:64] == '0))
      else $error("rates reported without a period");

endmodule
